// ===== rtl/core/lu_pkg.sv =====
// Shared types, codes and constants for the LU factor-and-solve engine.
// No dependencies; compiled first.
package lu_pkg;

   localparam int DATA_W                = 32;
   localparam int CSR_W                 = 4;
   localparam int DEF_MAX_ORDER         = 8;
   localparam int DEF_FRACTION_BITS     = 16;

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_LOAD_MAT = 3'd0,
      OP_FACTOR   = 3'd1,
      OP_LOAD_RHS = 3'd2,
      OP_SOLVE    = 3'd3,
      OP_READ_L   = 3'd4,
      OP_READ_U   = 3'd5
   } lu_op_type;

   typedef enum logic [1:0] {
      KIND_ACK  = 2'd0,
      KIND_SOLN = 2'd1,
      KIND_READ = 2'd2
   } lu_kind_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_ZERO_PIVOT   = 2'd1,
      ST_SATURATED    = 2'd2,
      ST_NOT_FACTORED = 2'd3
   } lu_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ACK,
      S_F_PIVRD,
      S_F_PIV,
      S_F_JCHK,
      S_F_DIVGO,
      S_F_DIVW,
      S_F_KCHK,
      S_F_KA,
      S_F_KQ,
      S_F_KSUB,
      S_RD,
      S_RD2,
      S_V_FI,
      S_V_FJ,
      S_V_FM,
      S_V_FT,
      S_V_FS,
      S_B_I,
      S_B_J,
      S_B_M,
      S_B_T,
      S_B_S,
      S_B_DIVGO,
      S_B_DIVW,
      S_EMIT
   } lu_state_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [DATA_W-1:0] quot;
   } lu_div_result_type;

endpackage

// ===== rtl/core/lu_req_if.sv =====
// Request channel of the LU engine: valid/ready plus one request payload.
// Depends on lu_pkg.
interface lu_req_if #(parameter int MAX_ORDER = lu_pkg::DEF_MAX_ORDER);
   localparam int IDX_W = $clog2(MAX_ORDER);

   logic                              valid;
   logic                              ready;
   logic [2:0]                        opcode;
   logic [IDX_W-1:0]                  row;
   logic [IDX_W-1:0]                  col;
   logic signed [lu_pkg::DATA_W-1:0]  value;

   modport source (output valid, output opcode, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input opcode, input row, input col, input value,
                   output ready);
endinterface

// ===== rtl/core/lu_rsp_if.sv =====
// Response channel of the LU engine: valid/ready plus one response payload.
// Depends on lu_pkg.
interface lu_rsp_if #(parameter int MAX_ORDER = lu_pkg::DEF_MAX_ORDER);
   localparam int IDX_W = $clog2(MAX_ORDER);

   logic                              valid;
   logic                              ready;
   logic [1:0]                        result_kind;
   logic [IDX_W-1:0]                  index;
   logic signed [lu_pkg::DATA_W-1:0]  data;
   logic [1:0]                        status;
   logic                              last;

   modport source (output valid, output result_kind, output index, output data,
                   output status, output last, input ready);
   modport sink   (input valid, input result_kind, input index, input data,
                   input status, input last, output ready);
endinterface

// ===== rtl/core/lu_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module lu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/lu_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and hands the
// partial remainder to the next cell. Depends on lu_pkg.
module lu_div_cell #(
   parameter int QW = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      valid_in,
   input  logic [lu_pkg::DATA_W-1:0] rem_in,
   input  logic [QW-1:0]             dvd_in,
   input  logic [QW-1:0]             quo_in,
   input  logic [lu_pkg::DATA_W-1:0] den_in,
   input  logic                      neg_in,
   output logic                      valid_out,
   output logic [lu_pkg::DATA_W-1:0] rem_out,
   output logic [QW-1:0]             dvd_out,
   output logic [QW-1:0]             quo_out,
   output logic [lu_pkg::DATA_W-1:0] den_out,
   output logic                      neg_out
);
   import lu_pkg::*;

   logic              valid_ff;
   logic [DATA_W-1:0] rem_ff, den_ff;
   logic [QW-1:0]     dvd_ff, quo_ff;
   logic              neg_ff;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              ge;

   always_comb begin
      trial = {rem_in, dvd_in[QW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = trial >= {1'b0, den_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dvd_ff <= {dvd_in[QW-2:0], 1'b0};
      quo_ff <= {quo_in[QW-2:0], ge};
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign dvd_out   = dvd_ff;
   assign quo_out   = quo_ff;
   assign den_out   = den_ff;
   assign neg_out   = neg_ff;
endmodule

// ===== rtl/core/lu_divider.sv =====
// Fixed-point divider: (num << FRACTION_BITS) / den, truncating, saturated.
// A chain of lu_div_cell stages, one quotient bit each. Depends on lu_pkg.
module lu_divider #(
   parameter int FRACTION_BITS = lu_pkg::DEF_FRACTION_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lu_pkg::DATA_W-1:0]     num,
   input  logic [lu_pkg::DATA_W-1:0]     den,
   output lu_pkg::lu_div_result_type     result
);
   import lu_pkg::*;

   localparam int QW = DATA_W + FRACTION_BITS;

   logic              stg_valid [QW+1];
   logic [DATA_W-1:0] stg_rem   [QW+1];
   logic [QW-1:0]     stg_dvd   [QW+1];
   logic [QW-1:0]     stg_quo   [QW+1];
   logic [DATA_W-1:0] stg_den   [QW+1];
   logic              stg_neg   [QW+1];

   logic              in_valid_ff;
   logic [DATA_W-1:0] in_den_ff;
   logic [QW-1:0]     in_dvd_ff;
   logic              in_neg_ff;
   logic [DATA_W-1:0] num_mag, den_mag;

   logic              done_ff;
   logic              ovf_ff;
   logic [DATA_W-1:0] quot_ff;
   logic [QW-1:0]     qm;
   logic              over;
   logic [DATA_W-1:0] qval;

   always_comb begin
      num_mag = num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
      den_mag = den[DATA_W-1] ? (~den + DATA_W'(1)) : den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      in_dvd_ff <= {num_mag, {FRACTION_BITS{1'b0}}};
      in_den_ff <= den_mag;
      in_neg_ff <= num[DATA_W-1] ^ den[DATA_W-1];
   end

   assign stg_valid[0] = in_valid_ff;
   assign stg_rem[0]   = '0;
   assign stg_dvd[0]   = in_dvd_ff;
   assign stg_quo[0]   = '0;
   assign stg_den[0]   = in_den_ff;
   assign stg_neg[0]   = in_neg_ff;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      lu_div_cell #(.QW(QW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (stg_valid[g]),
         .rem_in    (stg_rem[g]),
         .dvd_in    (stg_dvd[g]),
         .quo_in    (stg_quo[g]),
         .den_in    (stg_den[g]),
         .neg_in    (stg_neg[g]),
         .valid_out (stg_valid[g+1]),
         .rem_out   (stg_rem[g+1]),
         .dvd_out   (stg_dvd[g+1]),
         .quo_out   (stg_quo[g+1]),
         .den_out   (stg_den[g+1]),
         .neg_out   (stg_neg[g+1])
      );
   end

   // saturate magnitude to the signed range
   always_comb begin
      qm = stg_quo[QW];
      if (stg_neg[QW]) begin
         over = (|qm[QW-1:DATA_W]) || (qm[DATA_W-1] && (|qm[DATA_W-2:0]));
         qval = over ? DATA_MIN : (DATA_W'(0) - qm[DATA_W-1:0]);
      end else begin
         over = |qm[QW-1:DATA_W-1];
         qval = over ? DATA_MAX : qm[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= stg_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff  <= over;
      quot_ff <= qval;
   end

   assign result.done = done_ff;
   assign result.ovf  = ovf_ff;
   assign result.quot = quot_ff;
endmodule

// ===== rtl/core/lu_factor_and_solve.sv =====
// LU factor-and-solve engine, top level.
// Depends on lu_pkg, lu_req_if, lu_rsp_if, lu_ram, lu_divider.
//
// Usage: requests on req_bus (opcode, row, col, value) load matrix and rhs
// entries, start a factorization, start a solve or read back one L or U entry.
// Every request yields one response on rsp_bus, except a successful solve,
// which yields n solution responses with last set on the final one. The order
// n is written on csr_write_enable/csr_write_data; the user must write it only
// while the engine is idle, which the engine itself does not enforce. Loads,
// status-only answers and unused opcodes pass S_ACK into the output register,
// L/U reads pass S_RD and S_RD2 before S_ACK. During factorize each division
// goes through the F+32 stage divider cell chain and each update goes through
// the single 32x32 multiplier in 4 steps. Solve runs forward substitution,
// then back substitution with one division per row, then emits the solutions.
// One request is in work at a time; a new one is taken while the previous
// response still waits in the output register. Reset: order returns to
// MAX_ORDER, factored and saturation flags clear; the matrix and rhs stores
// hold no defined contents until loaded. When the receiver stalls, the
// response stays in the output register and the engine holds until it is
// taken.
module lu_factor_and_solve #(
   parameter int MAX_ORDER     = lu_pkg::DEF_MAX_ORDER,
   parameter int FRACTION_BITS = lu_pkg::DEF_FRACTION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   lu_req_if.sink                   req_bus,
   lu_rsp_if.source                 rsp_bus,
   input  logic                     csr_write_enable,
   input  logic [lu_pkg::CSR_W-1:0] csr_write_data
);
   import lu_pkg::*;

   localparam int IDX_W = $clog2(MAX_ORDER);
   localparam int CNT_W = $clog2(MAX_ORDER + 1);
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [63:0]       BIAS    = (64'd1 << FRACTION_BITS) - 64'd1;
   localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRACTION_BITS;

   function automatic logic [AW-1:0] mat_addr(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] c);
      mat_addr = AW'(r * MAX_ORDER + c);
   endfunction

   function automatic logic [CNT_W-1:0] clamp_order(input logic [CSR_W-1:0] v);
      int vi;
      vi = int'(v);
      if (vi == 0) clamp_order = CNT_W'(1);
      else if (vi > MAX_ORDER) clamp_order = CNT_W'(MAX_ORDER);
      else clamp_order = CNT_W'(vi);
   endfunction

   lu_state_type      state_ff, state_in;
   logic [CNT_W-1:0]  order_ff, order_in;
   logic              factored_ff, factored_in;
   logic              sat_ff, sat_in;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic              upper_ff, upper_in;
   logic [DATA_W-1:0] piv_ff, piv_in, m_ff, m_in, acc_ff, acc_in, t_ff, t_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [1:0]        res_kind_ff, res_kind_in, res_status_ff, res_status_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;
   logic [DATA_W-1:0] rhs_ff [MAX_ORDER];
   logic [DATA_W-1:0] work_ff [MAX_ORDER];

   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_kind_ff, out_status_ff;
   logic [IDX_W-1:0]  out_index_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_last_ff;

   logic              emit, slot_free;
   logic [1:0]        e_kind, e_status;
   logic [IDX_W-1:0]  e_index;
   logic [DATA_W-1:0] e_data;
   logic              e_last;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, rdata;

   logic              rhs_we, work_we;
   logic [IDX_W-1:0]  rhs_waddr;
   logic [DATA_W-1:0] rhs_wdata, work_wdata, work_rd;
   logic [CNT_W-1:0]  work_raddr, i_dec;

   logic [DATA_W-1:0] mul_a, mul_b;
   logic signed [63:0] mq_bias, mq_shift;
   logic              mq_ovf;
   logic [DATA_W-1:0] mq_val;
   logic signed [DATA_W:0] sd;
   logic              sub_ovf;
   logic [DATA_W-1:0] sub_val;

   logic              div_start;
   logic [DATA_W-1:0] div_num, div_den;
   lu_div_result_type div_res;

   logic              in_range;

   lu_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mat (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   lu_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .result (div_res)
   );

   // truncating product and saturating difference
   always_comb begin
      mq_bias  = prod_ff + (prod_ff[63] ? BIAS : 64'd0);
      mq_shift = mq_bias >>> FRACTION_BITS;
      mq_ovf   = !((&mq_shift[63:DATA_W-1]) || (~|mq_shift[63:DATA_W-1]));
      mq_val   = mq_ovf ? (mq_shift[63] ? DATA_MIN : DATA_MAX) : mq_shift[DATA_W-1:0];
      sd       = $signed({acc_ff[DATA_W-1], acc_ff}) - $signed({t_ff[DATA_W-1], t_ff});
      sub_ovf  = sd[DATA_W] ^ sd[DATA_W-1];
      sub_val  = sub_ovf ? (sd[DATA_W] ? DATA_MIN : DATA_MAX) : sd[DATA_W-1:0];
      prod_in  = $signed(mul_a) * $signed(mul_b);
   end

   assign i_dec     = i_ff - CNT_W'(1);
   assign work_rd   = work_ff[work_raddr[IDX_W-1:0]];
   assign slot_free = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign in_range  = (CNT_W'(row_ff) < order_ff) && (CNT_W'(col_ff) < order_ff);

   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      factored_in   = factored_ff;
      sat_in        = sat_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      upper_in      = upper_ff;
      piv_in        = piv_ff;
      m_in          = m_ff;
      acc_in        = acc_ff;
      t_in          = t_ff;
      res_kind_in   = res_kind_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = req_bus.value;
      ram_raddr     = '0;
      rhs_we        = 1'b0;
      rhs_waddr     = req_bus.row;
      rhs_wdata     = req_bus.value;
      work_we       = 1'b0;
      work_wdata    = acc_ff;
      work_raddr    = j_ff;
      mul_a         = rdata;
      mul_b         = work_rd;
      div_start     = 1'b0;
      div_num       = rdata;
      div_den       = piv_ff;
      emit          = 1'b0;
      e_kind        = res_kind_ff;
      e_index       = '0;
      e_data        = res_data_ff;
      e_status      = res_status_ff;
      e_last        = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            res_kind_in   = KIND_ACK;
            res_status_in = ST_OK;
            res_data_in   = '0;
            row_in        = req_bus.row;
            col_in        = req_bus.col;
            upper_in      = (req_bus.opcode == OP_READ_U);
            if (req_bus.valid) begin
               state_in = S_ACK;
               unique case (req_bus.opcode) inside
                  OP_LOAD_MAT: begin
                     factored_in = 1'b0;
                     if (int'(req_bus.row) < MAX_ORDER && int'(req_bus.col) < MAX_ORDER) begin
                        ram_we    = 1'b1;
                        ram_waddr = mat_addr(CNT_W'(req_bus.row), CNT_W'(req_bus.col));
                     end
                  end
                  OP_FACTOR: begin
                     sat_in      = 1'b0;
                     factored_in = 1'b0;
                     i_in        = '0;
                     state_in    = S_F_PIVRD;
                  end
                  OP_LOAD_RHS: begin
                     rhs_we = (int'(req_bus.row) < MAX_ORDER);
                  end
                  OP_SOLVE: begin
                     if (!factored_ff) begin
                        res_status_in = ST_NOT_FACTORED;
                     end else begin
                        i_in     = '0;
                        state_in = S_V_FI;
                     end
                  end
                  OP_READ_L, OP_READ_U: begin
                     res_kind_in = KIND_READ;
                     if (!factored_ff) begin
                        res_status_in = ST_NOT_FACTORED;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ACK: begin
            emit = 1'b1;
            if (slot_free) state_in = S_IDLE;
         end
         S_F_PIVRD: begin
            if (i_ff == order_ff) begin
               factored_in   = 1'b1;
               res_status_in = sat_ff ? ST_SATURATED : ST_OK;
               state_in      = S_ACK;
            end else begin
               ram_raddr = mat_addr(i_ff, i_ff);
               state_in  = S_F_PIV;
            end
         end
         S_F_PIV: begin
            if (rdata == '0) begin
               res_status_in = ST_ZERO_PIVOT;
               state_in      = S_ACK;
            end else begin
               piv_in   = rdata;
               j_in     = i_ff + CNT_W'(1);
               state_in = S_F_JCHK;
            end
         end
         S_F_JCHK: begin
            if (j_ff == order_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_F_PIVRD;
            end else begin
               ram_raddr = mat_addr(j_ff, i_ff);
               state_in  = S_F_DIVGO;
            end
         end
         S_F_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_F_DIVW;
         end
         S_F_DIVW: begin
            if (div_res.done) begin
               ram_we    = 1'b1;
               ram_waddr = mat_addr(j_ff, i_ff);
               ram_wdata = div_res.quot;
               m_in      = div_res.quot;
               sat_in    = sat_ff | div_res.ovf;
               k_in      = i_ff + CNT_W'(1);
               state_in  = S_F_KCHK;
            end
         end
         S_F_KCHK: begin
            if (k_ff == order_ff) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = S_F_JCHK;
            end else begin
               ram_raddr = mat_addr(i_ff, k_ff);
               state_in  = S_F_KA;
            end
         end
         S_F_KA: begin
            mul_a     = m_ff;
            mul_b     = rdata;
            ram_raddr = mat_addr(j_ff, k_ff);
            state_in  = S_F_KQ;
         end
         S_F_KQ: begin
            acc_in   = rdata;
            t_in     = mq_val;
            sat_in   = sat_ff | mq_ovf;
            state_in = S_F_KSUB;
         end
         S_F_KSUB: begin
            ram_we    = 1'b1;
            ram_waddr = mat_addr(j_ff, k_ff);
            ram_wdata = sub_val;
            sat_in    = sat_ff | sub_ovf;
            k_in      = k_ff + CNT_W'(1);
            state_in  = S_F_KCHK;
         end
         S_RD: begin
            if (in_range) ram_raddr = mat_addr(CNT_W'(row_ff), CNT_W'(col_ff));
            state_in = S_RD2;
         end
         S_RD2: begin
            res_data_in = '0;
            if (in_range) begin
               if (upper_ff) begin
                  if (row_ff <= col_ff) res_data_in = rdata;
               end else if (row_ff == col_ff) begin
                  res_data_in = ONE_VAL;
               end else if (row_ff > col_ff) begin
                  res_data_in = rdata;
               end
            end
            state_in = S_ACK;
         end
         S_V_FI: begin
            if (i_ff == order_ff) begin
               state_in = S_B_I;
            end else begin
               acc_in   = rhs_ff[i_ff[IDX_W-1:0]];
               j_in     = '0;
               state_in = S_V_FJ;
            end
         end
         S_V_FJ: begin
            if (j_ff == i_ff) begin
               work_we  = 1'b1;
               i_in     = i_ff + CNT_W'(1);
               state_in = S_V_FI;
            end else begin
               ram_raddr = mat_addr(i_ff, j_ff);
               state_in  = S_V_FM;
            end
         end
         S_V_FM: state_in = S_V_FT;
         S_V_FT: begin
            t_in     = mq_val;
            sat_in   = sat_ff | mq_ovf;
            state_in = S_V_FS;
         end
         S_V_FS: begin
            acc_in   = sub_val;
            sat_in   = sat_ff | sub_ovf;
            j_in     = j_ff + CNT_W'(1);
            state_in = S_V_FJ;
         end
         S_B_I: begin
            work_raddr = i_dec;
            if (i_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               i_in     = i_dec;
               acc_in   = work_rd;
               j_in     = i_ff;
               state_in = S_B_J;
            end
         end
         S_B_J: begin
            if (j_ff == order_ff) begin
               ram_raddr = mat_addr(i_ff, i_ff);
               state_in  = S_B_DIVGO;
            end else begin
               ram_raddr = mat_addr(i_ff, j_ff);
               state_in  = S_B_M;
            end
         end
         S_B_M: state_in = S_B_T;
         S_B_T: begin
            t_in     = mq_val;
            sat_in   = sat_ff | mq_ovf;
            state_in = S_B_S;
         end
         S_B_S: begin
            acc_in   = sub_val;
            sat_in   = sat_ff | sub_ovf;
            j_in     = j_ff + CNT_W'(1);
            state_in = S_B_J;
         end
         S_B_DIVGO: begin
            div_start = 1'b1;
            div_num   = acc_ff;
            div_den   = rdata;
            state_in  = S_B_DIVW;
         end
         S_B_DIVW: begin
            if (div_res.done) begin
               work_we    = 1'b1;
               work_wdata = div_res.quot;
               sat_in     = sat_ff | div_res.ovf;
               state_in   = S_B_I;
            end
         end
         S_EMIT: begin
            work_raddr = i_ff;
            emit       = 1'b1;
            e_kind     = KIND_SOLN;
            e_index    = i_ff[IDX_W-1:0];
            e_data     = work_rd;
            e_status   = sat_ff ? ST_SATURATED : ST_OK;
            e_last     = (i_ff + CNT_W'(1) == order_ff);
            if (slot_free) begin
               i_in = i_ff + CNT_W'(1);
               if (e_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_write_enable) begin
         order_in    = clamp_order(csr_write_data);
         factored_in = 1'b0;
      end
   end

   always_comb begin
      if (emit && slot_free) out_valid_in = 1'b1;
      else if (rsp_bus.ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= CNT_W'(MAX_ORDER);
         factored_ff  <= 1'b0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         factored_ff  <= factored_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      upper_ff      <= upper_in;
      piv_ff        <= piv_in;
      m_ff          <= m_in;
      acc_ff        <= acc_in;
      t_ff          <= t_in;
      prod_ff       <= prod_in;
      res_kind_ff   <= res_kind_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (rhs_we) rhs_ff[rhs_waddr] <= rhs_wdata;
      if (work_we) work_ff[i_ff[IDX_W-1:0]] <= work_wdata;
      if (emit && slot_free) begin
         out_kind_ff   <= e_kind;
         out_index_ff  <= e_index;
         out_data_ff   <= e_data;
         out_status_ff <= e_status;
         out_last_ff   <= e_last;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.result_kind = out_kind_ff;
   assign rsp_bus.index       = out_index_ff;
   assign rsp_bus.data        = out_data_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.last        = out_last_ff;
endmodule

// ===== rtl/core/lu_checker.sv =====
// Port-level checks for lu_factor_and_solve, attached by bind.
// Depends on lu_pkg and lu_factor_and_solve.
module lu_checker #(
   parameter int IDX_W = 3
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_kind,
   input logic [IDX_W-1:0]          rsp_index,
   input logic [lu_pkg::DATA_W-1:0] rsp_data,
   input logic [1:0]                rsp_status,
   input logic                      rsp_last
);
   import lu_pkg::*;

   // a stalled response is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in work at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_ack_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ACK |-> rsp_data == '0 && rsp_index == '0 && rsp_last)
      else $error("acknowledge carries payload");

   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ZERO_PIVOT || rsp_status == ST_NOT_FACTORED)
      |-> rsp_kind != KIND_SOLN && rsp_last)
      else $error("error status on a solution element");
endmodule

bind lu_factor_and_solve lu_checker #(.IDX_W($clog2(MAX_ORDER))) u_lu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_kind   (rsp_bus.result_kind),
   .rsp_index  (rsp_bus.index),
   .rsp_data   (rsp_bus.data),
   .rsp_status (rsp_bus.status),
   .rsp_last   (rsp_bus.last)
);

// ===== bench/tb.sv =====
// Self-checking bench for lu_factor_and_solve: directed table, then random phases.
// Depends on lu_pkg, lu_req_if, lu_rsp_if and the engine RTL.
module tb;
   import lu_pkg::*;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEM_TARGET = 400;

   typedef struct {
      logic [1:0]         kind;
      logic [2:0]         idx;
      logic signed [31:0] data;
      logic [1:0]         status;
      logic               last;
   } lu_result_type;

   typedef struct {
      bit                 is_csr;
      logic [2:0]         op;
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
      bit                 typed;
      logic [1:0]         kind;
      logic [1:0]         status;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_W-1:0] csr_write_data;

   lu_req_if req_bus ();
   lu_rsp_if rsp_bus ();

   lu_factor_and_solve dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic signed [31:0] mat[8][8];
   bit                 mat_set[8][8];
   logic signed [31:0] rhs_vec[8];
   bit                 rhs_set[8];
   logic signed [31:0] work_vec[8];
   bit                 factored;
   bit                 sat_flag;
   int                 order;

   lu_result_type pending_results[$];
   int  error_count;
   int  items_sent;
   int  idle_cycles;
   bit  quiet_tx;
   bit  quiet_rx;
   int  rx_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         sat_flag = 1'b1;
         return DATA_MAX;
      end
      if (v < -64'sd2147483648) begin
         sat_flag = 1'b1;
         return DATA_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] q;
      p = 64'(a) * 64'(b);
      if (p < 0) q = -((-p) >>> 16);
      else q = p >>> 16;
      return sat32(q);
   endfunction

   function automatic logic signed [31:0] fx_div(input logic signed [31:0] num,
                                                 input logic signed [31:0] den);
      logic signed [63:0] scaled;
      scaled = 64'(num) <<< 16;
      return sat32(scaled / 64'(den));
   endfunction

   function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return sat32(64'(a) - 64'(b));
   endfunction

   function automatic logic [1:0] lu_factorize();
      logic signed [31:0] pivot;
      logic signed [31:0] m;
      sat_flag = 1'b0;
      factored = 1'b0;
      for (int i = 0; i < order; i++) begin
         pivot = mat[i][i];
         if (pivot == 0) return ST_ZERO_PIVOT;
         for (int j = i + 1; j < order; j++) begin
            m = fx_div(mat[j][i], pivot);
            mat[j][i] = m;
            for (int k = i + 1; k < order; k++)
               mat[j][k] = fx_sub(mat[j][k], fx_mul(m, mat[i][k]));
         end
      end
      factored = 1'b1;
      return sat_flag ? ST_SATURATED : ST_OK;
   endfunction

   function automatic void lu_substitute();
      logic signed [31:0] acc;
      for (int i = 0; i < order; i++) begin
         acc = rhs_vec[i];
         for (int j = 0; j < i; j++) acc = fx_sub(acc, fx_mul(mat[i][j], work_vec[j]));
         work_vec[i] = acc;
      end
      for (int i = order - 1; i >= 0; i--) begin
         acc = work_vec[i];
         for (int j = i + 1; j < order; j++)
            acc = fx_sub(acc, fx_mul(mat[i][j], work_vec[j]));
         work_vec[i] = fx_div(acc, mat[i][i]);
      end
   endfunction

   function automatic void push_result(input logic [1:0] kind, input int idx,
                                       input logic signed [31:0] data,
                                       input logic [1:0] status, input bit last);
      lu_result_type r;
      r.kind = kind;
      r.idx = idx[2:0];
      r.data = data;
      r.status = status;
      r.last = last;
      pending_results.push_back(r);
   endfunction

   function automatic void compute_results(input logic [2:0] op, input logic [2:0] row,
                                           input logic [2:0] col,
                                           input logic signed [31:0] value);
      logic signed [31:0] d;
      logic [1:0] st;
      case (op) inside
         OP_LOAD_MAT: begin
            mat[row][col] = value;
            mat_set[row][col] = 1'b1;
            factored = 1'b0;
            push_result(KIND_ACK, 0, 0, ST_OK, 1'b1);
         end
         OP_FACTOR: begin
            st = lu_factorize();
            push_result(KIND_ACK, 0, 0, st, 1'b1);
         end
         OP_LOAD_RHS: begin
            rhs_vec[row] = value;
            rhs_set[row] = 1'b1;
            push_result(KIND_ACK, 0, 0, ST_OK, 1'b1);
         end
         OP_SOLVE: begin
            if (!factored) begin
               push_result(KIND_ACK, 0, 0, ST_NOT_FACTORED, 1'b1);
            end else begin
               lu_substitute();
               st = sat_flag ? ST_SATURATED : ST_OK;
               for (int i = 0; i < order; i++)
                  push_result(KIND_SOLN, i, work_vec[i], st, i == order - 1);
            end
         end
         OP_READ_L, OP_READ_U: begin
            d = 0;
            if (!factored) begin
               push_result(KIND_READ, 0, 0, ST_NOT_FACTORED, 1'b1);
            end else begin
               if (row < order && col < order) begin
                  if (op == OP_READ_L) begin
                     if (row == col) d = ONE;
                     else if (row > col) d = mat[row][col];
                  end else if (row <= col) begin
                     d = mat[row][col];
                  end
               end
               push_result(KIND_READ, 0, d, ST_OK, 1'b1);
            end
         end
         default: push_result(KIND_ACK, 0, 0, ST_OK, 1'b1);
      endcase
   endfunction

   task automatic send_req(input logic [2:0] op, input logic [2:0] row,
                           input logic [2:0] col, input logic signed [31:0] value);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.row    <= row;
      req_bus.col    <= col;
      req_bus.value  <= value;
      do @(posedge clock); while (!req_bus.ready);
      compute_results(op, row, col, value);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_order(input logic [3:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      order = (v == 0) ? 1 : (v > 8) ? 8 : v;
      factored = 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] unit_rand();
      return $signed($urandom_range(0, 2 * ONE)) - ONE;
   endfunction

   task automatic fill_matrix();
      for (int r = 0; r < order; r++)
         for (int c = 0; c < order; c++)
            if (!mat_set[r][c]) send_req(OP_LOAD_MAT, 3'(r), 3'(c), unit_rand());
   endtask

   task automatic fill_rhs();
      for (int i = 0; i < order; i++)
         if (!rhs_set[i]) send_req(OP_LOAD_RHS, 3'(i), 3'd0, unit_rand());
   endtask

   task automatic run_system(input int style);
      logic signed [31:0] v;
      int n;
      n = order;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            if (style == 0) v = $urandom;
            else if (r == c) v = ((n + 2) * ONE + unit_rand()) * ($urandom_range(0, 1) ? 1 : -1);
            else v = unit_rand();
            send_req(OP_LOAD_MAT, 3'(r), 3'(c), v);
         end
      if (style == 1) send_req(OP_LOAD_MAT, 3'($urandom_range(0, n - 1) * 9 % 8), 3'd0, 0);
      if (style == 1) begin
         v = $urandom_range(0, n - 1);
         send_req(OP_LOAD_MAT, v[2:0], v[2:0], 0);
      end
      send_req(OP_FACTOR, 3'd0, 3'd0, 0);
      repeat ($urandom_range(0, 3))
         send_req($urandom_range(0, 1) ? OP_READ_L : OP_READ_U,
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
      repeat ($urandom_range(1, 2)) begin
         for (int i = 0; i < n; i++)
            send_req(OP_LOAD_RHS, 3'(i), 3'($urandom_range(0, 7)),
                     style == 0 ? $signed($urandom) : 4 * unit_rand());
         send_req(OP_SOLVE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
      end
   endtask

   task automatic run_noise();
      logic [2:0] op;
      repeat (12) begin
         op = 3'($urandom_range(0, 7));
         if (op == OP_FACTOR) fill_matrix();
         if (op == OP_SOLVE && factored) fill_rhs();
         send_req(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
      end
   endtask

   stim_row_type directed[$] = '{
      '{0, OP_SOLVE,    0, 0, 0,        1, KIND_ACK,  ST_NOT_FACTORED},
      '{0, OP_READ_L,   1, 0, 0,        1, KIND_READ, ST_NOT_FACTORED},
      '{0, OP_READ_U,   0, 1, 0,        1, KIND_READ, ST_NOT_FACTORED},
      '{0, OP_SPARE_6,  7, 7, DATA_MAX, 1, KIND_ACK,  ST_OK},
      '{0, OP_SPARE_7,  0, 0, DATA_MIN, 1, KIND_ACK,  ST_OK},
      '{1, OP_LOAD_MAT, 0, 0, 2,        0, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_MAT, 0, 0, ONE,      1, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_MAT, 0, 1, 2 * ONE,  1, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_MAT, 1, 0, 3 * ONE,  1, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_MAT, 1, 1, 4 * ONE,  1, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_MAT, 7, 7, DATA_MIN, 1, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_RHS, 0, 7, ONE,      1, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_RHS, 1, 0, -5 * ONE, 1, KIND_ACK,  ST_OK},
      '{0, OP_FACTOR,   0, 0, 0,        0, KIND_ACK,  ST_OK},
      '{0, OP_READ_L,   1, 0, 0,        0, KIND_READ, ST_OK},
      '{0, OP_READ_L,   0, 0, 0,        0, KIND_READ, ST_OK},
      '{0, OP_READ_L,   0, 1, 0,        0, KIND_READ, ST_OK},
      '{0, OP_READ_U,   1, 0, 0,        0, KIND_READ, ST_OK},
      '{0, OP_READ_U,   1, 1, 0,        0, KIND_READ, ST_OK},
      '{0, OP_READ_U,   7, 7, 0,        1, KIND_READ, ST_OK},
      '{0, OP_SOLVE,    0, 0, 0,        0, KIND_SOLN, ST_OK},
      '{0, OP_LOAD_MAT, 0, 0, 0,        1, KIND_ACK,  ST_OK},
      '{0, OP_FACTOR,   0, 0, 0,        1, KIND_ACK,  ST_ZERO_PIVOT},
      '{0, OP_READ_U,   0, 0, 0,        1, KIND_READ, ST_NOT_FACTORED},
      '{0, OP_LOAD_MAT, 0, 0, 1,        1, KIND_ACK,  ST_OK},
      '{0, OP_LOAD_MAT, 1, 0, DATA_MAX, 1, KIND_ACK,  ST_OK},
      '{0, OP_FACTOR,   0, 0, 0,        0, KIND_ACK,  ST_OK},
      '{0, OP_SOLVE,    0, 0, 0,        0, KIND_SOLN, ST_OK}
   };

   // request side
   initial begin
      int phase;
      lu_result_type typed_rsp;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= '0;
      req_bus.row <= '0;
      req_bus.col <= '0;
      req_bus.value <= '0;
      for (int r = 0; r < 8; r++) begin
         rhs_set[r] = 1'b0;
         for (int c = 0; c < 8; c++) mat_set[r][c] = 1'b0;
      end
      factored = 1'b0;
      sat_flag = 1'b0;
      order = 8;
      quiet_tx = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            wait_drained();
            write_order(directed[i].value[3:0]);
         end else begin
            send_req(directed[i].op, directed[i].row, directed[i].col, directed[i].value);
            if (directed[i].typed) begin
               typed_rsp = '{directed[i].kind, 0, 0, directed[i].status, 1'b1};
               pending_results[$] = typed_rsp;
            end
         end
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         case (phase)
            0: write_order(4'd0);
            1: write_order(4'd15);
            2: write_order(4'd8);
            default:
               write_order(4'($urandom_range(0, 9) == 0 ? $urandom_range(9, 15)
                         : $urandom_range(0, 3) == 0 ? $urandom_range(5, 8)
                         : $urandom_range(1, 4)));
         endcase
         quiet_tx = ($urandom_range(0, 3) == 0);
         if (phase == 3) rx_hold = 300;
         if ($urandom_range(0, 4) == 0) run_noise();
         else run_system($urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2);
         phase++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   // result side
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      rx_hold = 0;
      quiet_rx = 1'b0;
      @(negedge reset);
      forever begin
         if (rx_hold > 0) stall = rx_hold;
         else stall = quiet_rx ? 0 : $urandom_range(0, 6);
         rx_hold = 0;
         if ($urandom_range(0, 40) == 0) quiet_rx = !quiet_rx;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin
      lu_result_type exp_rsp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d data %h", rsp_bus.result_kind, rsp_bus.data);
            error_count++;
         end else begin
            exp_rsp = pending_results.pop_front();
            if (rsp_bus.result_kind !== exp_rsp.kind) begin
               $error("result_kind: expected %0d, got %0d", exp_rsp.kind, rsp_bus.result_kind);
               error_count++;
            end
            if (rsp_bus.index !== exp_rsp.idx) begin
               $error("index: expected %0d, got %0d", exp_rsp.idx, rsp_bus.index);
               error_count++;
            end
            if (rsp_bus.data !== exp_rsp.data) begin
               $error("data: expected %h, got %h", exp_rsp.data, rsp_bus.data);
               error_count++;
            end
            if (rsp_bus.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.last !== exp_rsp.last) begin
               $error("last: expected %0d, got %0d", exp_rsp.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== lu_factor_and_solve.f =====
rtl/core/lu_pkg.sv
rtl/core/lu_req_if.sv
rtl/core/lu_rsp_if.sv
rtl/core/lu_ram.sv
rtl/core/lu_div_cell.sv
rtl/core/lu_divider.sv
rtl/core/lu_factor_and_solve.sv
rtl/core/lu_checker.sv
bench/tb.sv
